>>> src/fpfa_pkg.sv
// Shared constants and the scan token type for the fixed-partition allocator.
package fpfa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 24;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Placement policies
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  // Input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Token that walks the cell row, carrying the request and the best pick so far
  typedef struct packed {
    logic                 valid;
    logic                 have;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] req;
    logic [MODE_W-1:0]    mode;
  } scan_tok_t;

endpackage

>>> src/fixed_partition_fit_allocator.sv
// Fixed-partition allocator top level: request control, cell row and result register.
//
// A load request writes one partition size and frees that partition; the block
// stays ready for its next request. An allocate request sends a token down the
// row of MAX_BLOCKS cells, one cell per cycle, each cell keeping or replacing
// the pick by the fit policy; the token passes the head register and the cell
// registers, the row result is registered and then moved to the output register,
// and only then does the block take its next request. A finished result waits in
// the output register while further load requests are accepted; a new allocate
// holds at the row end until the previous result has been taken.
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [3:0]            load_index_i,
  input  logic [SIZE_BITS-1:0]  block_size_i,
  input  logic [SIZE_BITS-1:0]  request_size_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  placed_o,
  output logic [IDX_W-1:0]      placed_index_o,
  output logic [SIZE_BITS-1:0]  placed_block_size_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e               state_q;
  logic [MODE_W-1:0]    fit_mode_q;
  logic [CNT_W-1:0]     block_count_q;
  scan_tok_t            head_q;
  scan_tok_t            res_q;
  logic                 out_valid_q;
  logic                 placed_q;
  logic [IDX_W-1:0]     placed_index_q;
  logic [SIZE_BITS-1:0] placed_size_q;
  logic                 in_acc;
  logic                 out_free;
  logic                 deliver;
  scan_tok_t            chain [MAX_BLOCKS+1];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign deliver     = (state_q == ST_HOLD) && out_free;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= MODE_FIRST;
      block_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[MODE_W-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[CNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // Sequence requests, launch the token and hold the result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q.valid <= in_acc && (action_i == ACT_ALLOC);
      if (in_acc) begin
        head_q.have <= 1'b0;
        head_q.idx  <= '0;
        head_q.size <= '0;
        head_q.req  <= request_size_i;
        head_q.mode <= fit_mode_q;
      end
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (action_i == ACT_ALLOC)) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[MAX_BLOCKS].valid) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Capture the row result and the output payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && chain[MAX_BLOCKS].valid) begin
      res_q <= chain[MAX_BLOCKS];
    end
    if (deliver) begin
      placed_q       <= res_q.have;
      placed_index_q <= res_q.idx;
      placed_size_q  <= res_q.size;
    end
  end

  assign chain[0] = head_q;

  // Build the cell row
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic in_range;
    logic load;
    logic mark;

    assign in_range = (32'(g) < 32'(block_count_q));
    assign load     = in_acc && (action_i == ACT_LOAD) && (32'(load_index_i) == 32'(g));
    assign mark     = deliver && res_q.have && (res_q.idx == IDX_W'(g));

    fpfa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .my_idx_i    (IDX_W'(g)),
      .in_range_i  (in_range),
      .load_i      (load),
      .load_size_i (block_size_i),
      .mark_i      (mark),
      .tok_i       (chain[g]),
      .tok_o       (chain[g+1])
    );
  end

  assign out_valid_o         = out_valid_q;
  assign placed_o            = placed_q;
  assign placed_index_o      = placed_index_q;
  assign placed_block_size_o = placed_size_q;

endmodule

>>> src/fpfa_cell.sv
// One partition cell: holds a block size and its occupied flag, refines the passing token.
module fpfa_cell
  import fpfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     my_idx_i,
  input  logic                 in_range_i,
  input  logic                 load_i,
  input  logic [SIZE_BITS-1:0] load_size_i,
  input  logic                 mark_i,
  input  scan_tok_t            tok_i,
  output scan_tok_t            tok_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 occ_q;
  scan_tok_t            tok_q, tok_d;
  logic                 fits;
  logic                 take;

  // Test this block against the request and the current pick
  always_comb begin
    fits = in_range_i && !occ_q && (size_q >= tok_i.req);
    take = fits && (!tok_i.have ||
                    ((tok_i.mode == MODE_BEST)  && (size_q < tok_i.size)) ||
                    ((tok_i.mode == MODE_WORST) && (size_q > tok_i.size)));
    tok_d = tok_i;
    if (take) begin
      tok_d.have = 1'b1;
      tok_d.idx  = my_idx_i;
      tok_d.size = size_q;
    end
  end

  // Hold the occupied flag: a load frees, a mark occupies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (load_i) begin
      occ_q <= 1'b0;
    end else if (mark_i) begin
      occ_q <= 1'b1;
    end
  end

  // Hold the block size
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      size_q <= load_size_i;
    end
  end

  // Advance the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> test/tb_fixed_partition_fit_allocator.sv
// Testbench for the fixed-partition allocator: directed and random requests checked by a predictor.
module tb_fixed_partition_fit_allocator;
  import fpfa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ROW_LATENCY  = MAX_BLOCKS + 8;
  localparam int PHASE_ITEMS  = 58;
  localparam int PHASE_COUNT  = 12;
  localparam int QUIET_PHASES = 2;

  typedef struct packed {
    logic                 placed;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } placement_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  action      = ACT_LOAD;
  logic [3:0]            load_index  = '0;
  logic [SIZE_BITS-1:0]  block_size  = '0;
  logic [SIZE_BITS-1:0]  request_sz  = '0;
  logic                  out_ready   = 1'b0;
  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  placed_o;
  logic [IDX_W-1:0]      placed_index_o;
  logic [SIZE_BITS-1:0]  placed_block_size_o;

  // Predictor state: partition sizes, occupied flags and the two registers
  logic [SIZE_BITS-1:0] size_tab [MAX_BLOCKS];
  bit                   occ      [MAX_BLOCKS];
  logic [MODE_W-1:0]    mode_q   = MODE_FIRST;
  logic [CNT_W-1:0]     count_q  = '0;
  placement_t           placement_q [$];

  bit idle_on     = 1'b1;
  int stall_left  = 0;
  int err_count   = 0;
  int cycle_count = 0;

  fixed_partition_fit_allocator dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .action_i            (action),
    .load_index_i        (load_index),
    .block_size_i        (block_size),
    .request_size_i      (request_sz),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .placed_o            (placed_o),
    .placed_index_o      (placed_index_o),
    .placed_block_size_o (placed_block_size_o)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic int scan_limit();
    return (count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_q);
  endfunction

  // Pick a free partition by the fit policy; ties keep the lowest index
  function automatic placement_t predict_placement(logic [SIZE_BITS-1:0] req);
    placement_t res;
    bit have;
    bit done;
    int pick;
    have = 1'b0;
    done = 1'b0;
    pick = 0;
    for (int i = 0; i < scan_limit(); i++) begin
      if (!done && !occ[i] && size_tab[i] >= req) begin
        if (!have) begin
          have = 1'b1;
          pick = i;
          if (mode_q != MODE_BEST && mode_q != MODE_WORST) done = 1'b1;
        end else if (mode_q == MODE_BEST) begin
          if (size_tab[i] < size_tab[pick]) pick = i;
        end else if (mode_q == MODE_WORST) begin
          if (size_tab[i] > size_tab[pick]) pick = i;
        end
      end
    end
    if (have) begin
      occ[pick]  = 1'b1;
      res.placed = 1'b1;
      res.idx    = IDX_W'(pick);
      res.size   = size_tab[pick];
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Send one request, with an optional gap, and predict it once accepted
  task automatic send_item(logic act, logic [3:0] li, logic [SIZE_BITS-1:0] bs,
                           logic [SIZE_BITS-1:0] rq);
    placement_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    load_index <= li;
    block_size <= bs;
    request_sz <= rq;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    if (act == ACT_LOAD) begin
      size_tab[li] = bs;
      occ[li]      = 1'b0;
    end else begin
      want = predict_placement(rq);
      placement_q.insert(placement_q.size(), want);
    end
  endtask

  // Drop valid, drain all results, then let the row empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (ROW_LATENCY) @(posedge clk);
  endtask

  // Write one register; valid stays high across back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == CFG_FIT_MODE) mode_q = data[MODE_W-1:0];
    else count_q = data[CNT_W-1:0];
  endtask

  task automatic end_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] count);
    wait_idle();
    write_reg(CFG_FIT_MODE, {3'($urandom), mode});
    write_reg(CFG_BLOCK_COUNT, count);
    end_config();
  endtask

  // Check each accepted result against the oldest prediction; stall in bursts
  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (placement_q.size() == 0) begin
        report_mismatch("result with no pending allocate request");
      end else begin
        want = placement_q.pop_front();
        if (placed_o !== want.placed)
          report_mismatch($sformatf("placed %b, want %b", placed_o, want.placed));
        if (placed_index_o !== want.idx)
          report_mismatch($sformatf("placed_index %0d, want %0d", placed_index_o, want.idx));
        if (placed_block_size_o !== want.size)
          report_mismatch($sformatf("placed_block_size %0h, want %0h",
                                    placed_block_size_o, want.size));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Allocate with no partitions in use, then load every partition
  task automatic test_empty_row();
    logic [SIZE_BITS-1:0] sizes [MAX_BLOCKS];
    sizes[0] = '0;
    sizes[1] = 24'd100;
    sizes[2] = 24'd50;
    sizes[3] = 24'd100;
    sizes[4] = '1;
    sizes[5] = '1;
    for (int i = 6; i < MAX_BLOCKS; i++) sizes[i] = 24'h000400 + SIZE_BITS'(i * 37);
    send_item(ACT_ALLOC, '0, '0, '0);
    for (int i = 0; i < MAX_BLOCKS; i++) send_item(ACT_LOAD, 4'(i), sizes[i], '0);
  endtask

  // Unused mode acts as first fit; oversized count scans every partition
  task automatic test_first_fit_edges();
    configure(2'd3, 5'd31);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '1);
  endtask

  // Smallest fitting partition, equal sizes go to the lower index
  task automatic test_best_fit_ties();
    configure(MODE_BEST, 5'd16);
    send_item(ACT_ALLOC, '0, '0, 24'd60);
    send_item(ACT_ALLOC, '0, '0, 24'd60);
  endtask

  // Largest partition; reload of an occupied partition frees it
  task automatic test_worst_fit_reload();
    configure(MODE_WORST, 5'd16);
    send_item(ACT_ALLOC, '0, '0, 24'd1);
    send_item(ACT_ALLOC, '0, '0, '1);
    send_item(ACT_LOAD, 4'd4, '1, '0);
    send_item(ACT_ALLOC, '0, '0, '1);
  endtask

  // One random request, with requests mostly aimed at sizes in the table
  task automatic send_random_item();
    int lim;
    int pick;
    logic [3:0] li;
    logic [SIZE_BITS-1:0] sz;
    logic [SIZE_BITS-1:0] rq;
    lim = scan_limit();
    li = (lim > 0 && $urandom_range(0, 3) != 0) ? 4'($urandom_range(0, lim - 1))
                                                : 4'($urandom);
    case ($urandom_range(0, 3))
      0:       sz = SIZE_BITS'($urandom);
      1:       sz = $urandom_range(0, 1) ? '0 : '1;
      default: sz = SIZE_BITS'($urandom_range(0, 255));
    endcase
    pick = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
    case ($urandom_range(0, 7))
      0:       rq = SIZE_BITS'($urandom);
      1:       rq = $urandom_range(0, 1) ? '0 : '1;
      2:       rq = size_tab[pick] + 1'b1;
      3:       rq = size_tab[pick] - 1'b1;
      4:       rq = SIZE_BITS'($urandom_range(0, 255));
      default: rq = size_tab[pick];
    endcase
    if ($urandom_range(0, 9) < 4) send_item(ACT_LOAD, li, sz, rq);
    else send_item(ACT_ALLOC, li, sz, rq);
  endtask

  // Random traffic over every mode and a spread of partition counts
  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts [PHASE_COUNT];
    counts = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd16, 5'd5, 5'd17, 5'd16, 5'd8, 5'd16, 5'd3, 5'd16};
    counts[5] = CNT_W'($urandom_range(1, 15));
    counts[8] = CNT_W'($urandom_range(0, 31));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      configure(MODE_W'(p), counts[p]);
      if (p >= PHASE_COUNT - QUIET_PHASES) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_row();
    test_first_fit_edges();
    test_best_fit_ties();
    test_worst_fit_reload();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
